/* src/gals_pkg.sv */
// shared types, constants and helpers for the gray auto-level stretch block
package gals_pkg;

  // widths of the sample path
  localparam int MAX_SAMPLE_BITS = 32;
  localparam int SAMPLE_W        = 32;
  localparam int GRAY_BITS       = 8;
  localparam int NUM_W           = SAMPLE_W + GRAY_BITS;
  localparam int GRAY_MAX        = (1 << GRAY_BITS) - 1;
  localparam int STEP_W          = $clog2(GRAY_BITS);

  // command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // register port
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int CFG_IDX_LSB = 2;

  // register indexes
  localparam logic REG_AUTO_LEVEL  = 1'b0;
  localparam logic REG_PIXEL_BYTES = 1'b1;

  // sample width codes, the reserved code reads as four bytes
  localparam logic [1:0] BYTES_1 = 2'd0;
  localparam logic [1:0] BYTES_2 = 2'd1;
  localparam logic [1:0] BYTES_4 = 2'd2;

  // pass codes of an item
  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_OUTPUT  = 1'b1;

  typedef struct packed {
    logic       auto_level;
    logic [1:0] bytes_code;
  } cfg_t;

  // one queued command for the back end
  typedef struct packed {
    logic                 divide;
    logic [GRAY_BITS-1:0] gray;
    logic [SAMPLE_W-1:0]  diff;
    logic [SAMPLE_W-1:0]  span;
    logic [SAMPLE_W-1:0]  min;
    logic [SAMPLE_W-1:0]  max;
    logic                 last;
  } cmd_t;

  // mask of the used sample bits for a width code
  function automatic logic [SAMPLE_W-1:0] sample_mask(input logic [1:0] code);
    logic [6:0] w;
    unique case (code)
      BYTES_1: w = 7'd8;
      BYTES_2: w = 7'd16;
      default: w = 7'd32;
    endcase
    if (w > 7'(MAX_SAMPLE_BITS)) w = 7'(MAX_SAMPLE_BITS);
    return SAMPLE_W'((33'd1 << w) - 33'd1);
  endfunction

  // right shift that brings the top byte of a sample down
  function automatic logic [4:0] top_shift(input logic [1:0] code);
    logic [4:0] s;
    unique case (code)
      BYTES_1: s = 5'd0;
      BYTES_2: s = 5'd8;
      default: s = 5'd24;
    endcase
    return s;
  endfunction

endpackage

/* src/gals_regs.sv */
// configuration registers behind the bus port
module gals_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gals_pkg::CFG_AW-1:0] paddr,
  input  logic [gals_pkg::CFG_DW-1:0] pwdata,
  output logic [gals_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output gals_pkg::cfg_t              cfg
);

  logic       auto_level_r;
  logic [1:0] bytes_code_r;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[gals_pkg::CFG_IDX_LSB];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_level_r <= 1'b0;
      bytes_code_r <= gals_pkg::BYTES_1;
    end else if (wr_en) begin
      unique case (reg_idx)
        gals_pkg::REG_AUTO_LEVEL:  auto_level_r <= pwdata[0];
        gals_pkg::REG_PIXEL_BYTES: bytes_code_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      gals_pkg::REG_AUTO_LEVEL:  prdata = gals_pkg::CFG_DW'(auto_level_r);
      gals_pkg::REG_PIXEL_BYTES: prdata = gals_pkg::CFG_DW'(bytes_code_r);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.auto_level = auto_level_r;
  assign cfg.bytes_code = bytes_code_r;

endmodule

/* src/gals_front.sv */
// front end: takes items, tracks min and max, classifies each output item
module gals_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gals_pkg::cfg_t                cfg,
  input  logic                          in_push,
  input  logic [gals_pkg::SAMPLE_W-1:0] in_pixel_value,
  input  logic                          in_mode,
  input  logic                          in_frame_first,
  input  logic                          in_frame_last,
  input  logic                          fifo_full,
  output logic                          in_full,
  output logic                          cmd_push,
  output gals_pkg::cmd_t                cmd
);

  logic [gals_pkg::SAMPLE_W-1:0] running_min_r, running_min_nxt;
  logic [gals_pkg::SAMPLE_W-1:0] running_max_r, running_max_nxt;
  logic [gals_pkg::SAMPLE_W-1:0] p;
  logic [gals_pkg::SAMPLE_W-1:0] q;
  logic [gals_pkg::SAMPLE_W-1:0] shifted;
  logic                          accept;
  logic                          mapping;
  logic                          flat;

  assign in_full = fifo_full;
  assign accept  = in_push & ~fifo_full;
  assign p       = in_pixel_value & gals_pkg::sample_mask(cfg.bytes_code);
  assign mapping = (in_mode == gals_pkg::MODE_OUTPUT) & cfg.auto_level;

  // min and max update for every pass that measures
  always_comb begin
    running_min_nxt = running_min_r;
    running_max_nxt = running_max_r;
    if (!mapping) begin
      if (in_frame_first) begin
        running_min_nxt = p;
        running_max_nxt = p;
      end else begin
        if (p < running_min_r) running_min_nxt = p;
        if (p > running_max_r) running_max_nxt = p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_min_r <= '1;
      running_max_r <= '0;
    end else if (accept) begin
      running_min_r <= running_min_nxt;
      running_max_r <= running_max_nxt;
    end
  end

  // saturate the sample into the measured range for the map pass
  always_comb begin
    q = p;
    if (q < running_min_r) q = running_min_r;
    if (q > running_max_r) q = running_max_r;
  end

  assign flat    = ~(running_min_r < running_max_r);
  assign shifted = p >> gals_pkg::top_shift(cfg.bytes_code);

  // command to the back end
  always_comb begin
    cmd.divide = mapping & ~flat;
    cmd.gray   = mapping ? '0 : shifted[gals_pkg::GRAY_BITS-1:0];
    cmd.diff   = q - running_min_r;
    cmd.span   = running_max_r - running_min_r;
    cmd.min    = running_min_nxt;
    cmd.max    = running_max_nxt;
    cmd.last   = in_frame_last;
  end

  assign cmd_push = accept & (in_mode == gals_pkg::MODE_OUTPUT);

endmodule

/* src/gals_fifo.sv */
// short command queue between front and back end
module gals_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gals_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output gals_pkg::cmd_t pop_cmd,
  output logic           empty
);

  localparam int AW = gals_pkg::FIFO_AW;
  localparam int DEPTH = gals_pkg::FIFO_DEPTH;

  gals_pkg::cmd_t entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign pop_cmd = entry_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* src/gals_back.sv */
// back end: restoring divider for the stretch and the result register
module gals_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gals_pkg::cmd_t                 cmd,
  input  logic                           cmd_valid,
  output logic                           cmd_pop,
  output logic                           busy,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [gals_pkg::GRAY_BITS-1:0] out_gray_out,
  output logic [gals_pkg::SAMPLE_W-1:0]  out_frame_min,
  output logic [gals_pkg::SAMPLE_W-1:0]  out_frame_max,
  output logic                           out_last_out
);

  localparam int NW = gals_pkg::NUM_W;
  localparam int GB = gals_pkg::GRAY_BITS;
  localparam int SW = gals_pkg::STEP_W;

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  state_t          state_r;
  logic            out_valid_r;
  logic [GB-1:0]   gray_r;
  logic [gals_pkg::SAMPLE_W-1:0] min_r;
  logic [gals_pkg::SAMPLE_W-1:0] max_r;
  logic            last_r;
  logic [NW-1:0]   rem_r;
  logic [NW-1:0]   dsr_r;
  logic [GB-1:0]   quot_r;
  logic [SW-1:0]   cnt_r;
  logic            slot_free;
  logic            ge;
  logic [GB-1:0]   quot_nxt;

  assign slot_free = ~out_valid_r | out_pop;
  assign cmd_pop   = (state_r == ST_IDLE) & cmd_valid & slot_free;
  assign busy      = (state_r == ST_DIV);

  // one quotient bit per step
  assign ge       = (rem_r >= dsr_r);
  assign quot_nxt = {quot_r[GB-2:0], ge};

  // sequencer, divider and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_pop) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            min_r  <= cmd.min;
            max_r  <= cmd.max;
            last_r <= cmd.last;
            if (cmd.divide) begin
              rem_r   <= NW'(cmd.diff) * NW'(gals_pkg::GRAY_MAX);
              dsr_r   <= NW'(cmd.span) << (GB - 1);
              quot_r  <= '0;
              cnt_r   <= '0;
              state_r <= ST_DIV;
            end else begin
              gray_r      <= cmd.gray;
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (ge) rem_r <= rem_r - dsr_r;
          dsr_r  <= dsr_r >> 1;
          quot_r <= quot_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == SW'(GB - 1)) begin
            gray_r      <= quot_nxt;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_empty     = ~out_valid_r;
  assign out_gray_out  = gray_r;
  assign out_frame_min = min_r;
  assign out_frame_max = max_r;
  assign out_last_out  = last_r;

endmodule

/* src/gray_auto_level_stretch.sv */
// top level of the gray auto-level stretch block
//
// Converts raw gray samples of 1, 2 or 4 bytes to 8-bit gray. Items enter on
// a queue-style port (in_push / in_full) and results leave on another
// (out_empty / out_pop); the oldest result sits on the out_ ports while
// out_empty is low. Registers auto_level (byte 0) and pixel_bytes_code
// (byte 4) are to be written by the user over the bus port only while the
// block is idle; the block does not enforce this. Measure-pass items (mode 0)
// update min and max and give no result. The front end handles one item per
// cycle while its two-entry command queue is not full. A plain result
// passes through that queue and the result register; a stretched result
// also runs through the 8-step restoring divider, during which the back end
// takes no new command. Other items sustain one per cycle while results are
// popped. When out_pop stays low the result register and queue fill, then
// in_full rises and input items wait. Reset clears the registers, the queue
// and the result register; running min becomes all ones and running max zero.
module gray_auto_level_stretch (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gals_pkg::CFG_AW-1:0]    paddr,
  input  logic [gals_pkg::CFG_DW-1:0]    pwdata,
  output logic [gals_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [gals_pkg::SAMPLE_W-1:0]  in_pixel_value,
  input  logic                           in_mode,
  input  logic                           in_frame_first,
  input  logic                           in_frame_last,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [gals_pkg::GRAY_BITS-1:0] out_gray_out,
  output logic [gals_pkg::SAMPLE_W-1:0]  out_frame_min,
  output logic [gals_pkg::SAMPLE_W-1:0]  out_frame_max,
  output logic                           out_last_out
);

  gals_pkg::cfg_t cfg;
  gals_pkg::cmd_t push_cmd;
  gals_pkg::cmd_t pop_cmd;
  logic           fifo_push;
  logic           fifo_full;
  logic           fifo_pop;
  logic           fifo_empty;
  logic           back_busy;

  // register port
  gals_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front end
  gals_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_push        (in_push),
    .in_pixel_value (in_pixel_value),
    .in_mode        (in_mode),
    .in_frame_first (in_frame_first),
    .in_frame_last  (in_frame_last),
    .fifo_full      (fifo_full),
    .in_full        (in_full),
    .cmd_push       (fifo_push),
    .cmd            (push_cmd)
  );

  // command queue
  gals_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  // back end
  gals_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (pop_cmd),
    .cmd_valid     (~fifo_empty),
    .cmd_pop       (fifo_pop),
    .busy          (back_busy),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_gray_out  (out_gray_out),
    .out_frame_min (out_frame_min),
    .out_frame_max (out_frame_max),
    .out_last_out  (out_last_out)
  );

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full) else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty) else $error("command popped from an empty queue");

  a_div_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    back_busy |-> out_empty) else $error("divider running while result waits");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(back_busy) |-> ##8 !back_busy) else $error("divider length wrong");

endmodule
